@@ sv/spq_pkg.sv @@
// Shared constants, payload types and control structs of the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Number of entries the queue can hold.
  localparam int CAPACITY = 16;
  // Width of the entry counter, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width of the occupancy field of a result item.
  localparam int OCC_W = 5;

  // Operation codes of an input item.
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Fields of one input item.
  typedef struct packed {
    logic               operation;
    logic [15:0]        job_tag;
    logic signed [15:0] priority_req;
  } spq_in_t;

  // Fields of one result item.
  typedef struct packed {
    logic               accepted;
    logic               valid_res;
    logic [15:0]        out_tag;
    logic signed [15:0] out_priority;
    logic [OCC_W-1:0]   occupancy;
    logic               empty_res;
  } spq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic remove;
    logic load;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

@@ sv/spq_ctrl.sv @@
// Controller of the stable priority queue: handshakes and command decode.
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  // State codes: no result held, or a result waits in the output register.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  // An item may enter when the output register is free or is being taken.
  assign in_stall  = (state_r == ST_HOLD) && out_stall;
  assign out_valid = (state_r == ST_HOLD);
  assign accept    = in_valid && !in_stall;

  // Decode the item into datapath commands.
  always_comb begin
    cmd.load   = accept;
    cmd.insert = accept && (in_operation == OP_ENQ) && !stat.full;
    cmd.remove = accept && (in_operation == OP_DEQ) && !stat.empty;
  end

  // Next state of the output handshake.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!accept && !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/spq_datapath.sv @@
// Datapath of the stable priority queue: sorted row of entry cells and result register.
`timescale 1ns / 1ps

module spq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::spq_cmd_t  cmd,
  input  spq_pkg::spq_in_t   in_data,
  output spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_out_t  out_data
);
  import spq_pkg::*;

  logic [15:0]        tag_r  [CAPACITY];
  logic signed [15:0] prio_r [CAPACITY];
  logic [15:0]        tag_nxt  [CAPACITY];
  logic signed [15:0] prio_nxt [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] le;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  spq_out_t           res_r;
  spq_out_t           res_nxt;

  assign stat.full  = (count_r == CNT_W'(CAPACITY));
  assign stat.empty = (count_r == '0);

  // Each cell knows whether it is occupied and whether it stays ahead of the new entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count_r);
    assign le[i]  = occ[i] && (prio_r[i] <= in_data.priority_req);

    // Cell update: keep, take the new entry, shift down on insert, shift up on remove.
    always_comb begin
      tag_nxt[i]  = tag_r[i];
      prio_nxt[i] = prio_r[i];
      if (cmd.insert) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i-1]) begin
            tag_nxt[i]  = in_data.job_tag;
            prio_nxt[i] = in_data.priority_req;
          end else begin
            tag_nxt[i]  = tag_r[(i == 0) ? 0 : i-1];
            prio_nxt[i] = prio_r[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd.remove && (i < CAPACITY - 1)) begin
        tag_nxt[i]  = tag_r[(i < CAPACITY - 1) ? i+1 : i];
        prio_nxt[i] = prio_r[(i < CAPACITY - 1) ? i+1 : i];
      end
    end

    always_ff @(posedge clk) begin
      tag_r[i]  <= tag_nxt[i];
      prio_r[i] <= prio_nxt[i];
    end
  end

  // Entry count follows the commands.
  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Result item built from the front entry and the new count.
  always_comb begin
    res_nxt.accepted     = cmd.insert;
    res_nxt.valid_res    = cmd.remove;
    res_nxt.out_tag      = cmd.remove ? tag_r[0] : 16'd0;
    res_nxt.out_priority = cmd.remove ? prio_r[0] : 16'sd0;
    res_nxt.occupancy    = OCC_W'(count_nxt);
    res_nxt.empty_res    = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule

@@ sv/stable_priority_queue.sv @@
// Top level of the stable priority queue.
// An accepted item's result is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle unless a held result stalls; the compare-and-shift cells
// insert or remove one entry per cycle and the output register decouples the two sides.
// Reset clears the entry count and the output handshake; entry storage is not cleared.
`timescale 1ns / 1ps

module stable_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  // Handshake control and command decode.
  spq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_data.operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Sorted entry cells and result register.
  spq_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

@@ tb/stable_priority_queue_tb.sv @@
// Self-checking testbench of the stable priority queue, built around a sorted-list predictor.
`timescale 1ns / 1ps

module stable_priority_queue_tb;
  import spq_pkg::*;

  // Cycles without any accepted item before the run is declared hung.
  localparam int QUIET_LIMIT = 1000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  spq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spq_out_t out_data;

  // Predicted queue contents, kept in service order.
  logic [15:0]        sorted_tags [CAPACITY];
  logic signed [15:0] sorted_prios [CAPACITY];
  int                 sorted_count = 0;

  // Results still owed by the block, oldest first.
  spq_out_t pending_results [$];

  int error_count = 0;
  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  stable_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running 10 ns clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one item to the predicted queue and return the result it should produce.
  function automatic spq_out_t predict_queue(spq_in_t item);
    spq_out_t           res;
    logic signed [15:0] prio;
    int                 pos;
    res = '0;
    prio = item.priority_req;
    if (item.operation == OP_ENQ) begin
      if (sorted_count < CAPACITY) begin
        // A new job goes behind every entry of equal or better priority.
        pos = 0;
        while (pos < sorted_count && sorted_prios[pos] <= prio) pos++;
        for (int i = sorted_count; i > pos; i--) begin
          sorted_tags[i]  = sorted_tags[i-1];
          sorted_prios[i] = sorted_prios[i-1];
        end
        sorted_tags[pos]  = item.job_tag;
        sorted_prios[pos] = prio;
        sorted_count++;
        res.accepted = 1'b1;
      end
    end else if (sorted_count > 0) begin
      res.valid_res    = 1'b1;
      res.out_tag      = sorted_tags[0];
      res.out_priority = sorted_prios[0];
      for (int i = 1; i < sorted_count; i++) begin
        sorted_tags[i-1]  = sorted_tags[i];
        sorted_prios[i-1] = sorted_prios[i];
      end
      sorted_count--;
    end
    res.occupancy = OCC_W'(sorted_count);
    res.empty_res = (sorted_count == 0);
    return res;
  endfunction

  // Build a random item; narrow priorities crowd the queue with ties.
  function automatic spq_in_t random_item(int enq_pct, bit narrow_prios);
    spq_in_t item;
    item.operation = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
    item.job_tag   = 16'($urandom);
    if (narrow_prios) begin
      item.priority_req = 16'($urandom_range(0, 4) - 2);
    end else begin
      item.priority_req = 16'($urandom);
    end
    return item;
  endfunction

  // Offer one item, wait until the block takes it, then record its expected result.
  task automatic send_item(spq_in_t item);
    @(negedge clk);
    if (sender_idle && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    pending_results.push_back(predict_queue(item));
  endtask

  task automatic send_fields(logic op, logic [15:0] tag, logic [15:0] prio);
    spq_in_t item;
    item.operation    = op;
    item.job_tag      = tag;
    item.priority_req = prio;
    send_item(item);
  endtask

  // Stop offering items until every outstanding result has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Dequeues on an empty queue, with junk in the unused fields.
  task automatic test_empty_dequeue();
    send_fields(OP_DEQ, 16'hFFFF, 16'hFFFF);
    send_fields(OP_DEQ, 16'h0000, 16'h0000);
  endtask

  // Extreme tags and priorities, drained past empty.
  task automatic test_priority_extremes();
    send_fields(OP_ENQ, 16'hFFFF, 16'h7FFF);
    send_fields(OP_ENQ, 16'h0000, 16'h8000);
    send_fields(OP_ENQ, 16'h1234, 16'h0000);
    send_fields(OP_ENQ, 16'h8000, 16'hFFFF);
    repeat (5) send_fields(OP_DEQ, 16'h0000, 16'h0000);
  endtask

  // Equal priorities must leave in arrival order.
  task automatic test_equal_priorities();
    send_fields(OP_ENQ, 16'h0001, 16'h0005);
    send_fields(OP_ENQ, 16'h0002, 16'h0005);
    send_fields(OP_ENQ, 16'h0003, 16'h0005);
    send_fields(OP_ENQ, 16'h0004, 16'h0004);
    send_fields(OP_ENQ, 16'h0005, 16'h0005);
    repeat (5) send_fields(OP_DEQ, 16'h5A5A, 16'hA5A5);
  endtask

  // Fill to capacity, push against the full queue, then drain past empty.
  task automatic test_fill_and_drain(bit narrow_prios);
    spq_in_t item;
    for (int i = 0; i < CAPACITY; i++) begin
      item = random_item(100, narrow_prios);
      send_item(item);
    end
    send_fields(OP_ENQ, 16'hBEEF, 16'h8000);
    send_fields(OP_ENQ, 16'h0F0F, 16'h7FFF);
    repeat (CAPACITY + 1) send_fields(OP_DEQ, 16'($urandom), 16'($urandom));
  endtask

  // Segments with different enqueue bias so occupancy sweeps from empty to full.
  task automatic test_random_mix();
    int enq_pct;
    for (int seg = 0; seg < 14; seg++) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 25;
        1: enq_pct = 50;
        default: enq_pct = 75;
      endcase
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      repeat (55) send_item(random_item(enq_pct, $urandom_range(0, 1)));
      if (seg % 4 == 3) hold_until_drained();
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    repeat (100) send_item(random_item(55, $urandom_range(0, 1)));
  endtask

  // Receiver stalls in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (receiver_idle && $urandom_range(0, 99) < 12) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    spq_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("accepted", want.accepted, out_data.accepted);
        report_field("valid_res", want.valid_res, out_data.valid_res);
        report_field("out_tag", want.out_tag, out_data.out_tag);
        report_field("out_priority", want.out_priority, out_data.out_priority);
        report_field("occupancy", want.occupancy, out_data.occupancy);
        report_field("empty_res", want.empty_res, out_data.empty_res);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL stable_priority_queue");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    test_empty_dequeue();
    test_priority_extremes();
    test_equal_priorities();
    test_fill_and_drain(1'b1);
    hold_until_drained();
    test_random_mix();
    sender_idle = 1'b0;
    test_fill_and_drain(1'b0);
    test_steady_stream();

    hold_until_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS stable_priority_queue");
    end else begin
      $display("FAIL stable_priority_queue");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/stable_priority_queue.sv
tb/stable_priority_queue_tb.sv
